// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock while out of reset.
`define PITT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never occurs while out of reset.
`define PITT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== src/pitt_pkg.sv =====
package pitt_pkg;

    localparam int FIELD_W    = 32;
    localparam int COORD_BITS = 32;
    localparam int DW         = COORD_BITS + 1;   // coordinate difference
    localparam int PW         = 2 * DW;           // product of two differences
    localparam int CW         = PW + 1;           // cross product component
    localparam int MW         = CW;               // component magnitude
    localparam int LO         = (MW + 1) / 2;
    localparam int HI         = MW - LO;
    localparam int HHW        = 2 * HI;
    localparam int HLW        = HI + LO;
    localparam int LLW        = 2 * LO;
    localparam int SQW        = 2 * MW;           // squared component
    localparam int RADW       = SQW + 2;          // squared cross length
    localparam int RW         = RADW / 2;         // root width
    localparam int REMW       = RW + 3;
    localparam int SW         = RW + 2;           // sum of three roots
    localparam int TOL_W      = 16;
    localparam int TOL_SHIFT  = 20;
    localparam int RHSW       = TOL_W + RW;
    localparam int CMPW       = (SW + TOL_SHIFT > RHSW) ? SW + TOL_SHIFT : RHSW;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd105;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTRW     = $clog2(Q_DEPTH);
    localparam int Q_CNTW     = $clog2(Q_DEPTH + 1);
    localparam int F_LAST     = 7;                // last front stage

    typedef logic signed [COORD_BITS-1:0] crd_t;
    typedef logic signed [DW-1:0]         dif_t;
    typedef logic signed [PW-1:0]         prod_t;
    typedef logic signed [CW-1:0]         comp_t;
    typedef logic [MW-1:0]                mag_t;
    typedef logic [RADW-1:0]              rad_t;
    typedef logic [RW-1:0]                root_t;

    typedef struct packed {
        dif_t x;
        dif_t y;
        dif_t z;
    } vec_t;

    typedef struct packed {
        logic [FIELD_W-1:0] a_x;
        logic [FIELD_W-1:0] a_y;
        logic [FIELD_W-1:0] a_z;
        logic [FIELD_W-1:0] b_x;
        logic [FIELD_W-1:0] b_y;
        logic [FIELD_W-1:0] b_z;
        logic [FIELD_W-1:0] c_x;
        logic [FIELD_W-1:0] c_y;
        logic [FIELD_W-1:0] c_z;
        logic [FIELD_W-1:0] q_x;
        logic [FIELD_W-1:0] q_y;
        logic [FIELD_W-1:0] q_z;
    } tri_word_t;

    typedef struct packed {
        rad_t whole;
        rad_t s0;
        rad_t s1;
        rad_t s2;
    } sq_set_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        rad_t             rad;
        logic [REMW-1:0]  rem;
        root_t            root;
    } sqrt_st_t;

    // One digit of the restoring square root.
    function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        sqrt_st_t        r;
        rem_sh = {s.rem[REMW-3:0], s.rad[RADW-1 -: 2]};
        trial  = {1'b0, s.root, 2'b01};
        r.rad  = {s.rad[RADW-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {s.root[RW-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {s.root[RW-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== src/pitt_cross.sv =====
module pitt_cross (
    input  logic          clk,
    input  logic          en,
    input  pitt_pkg::vec_t u,
    input  pitt_pkg::vec_t v,
    output pitt_pkg::rad_t sq
);
    import pitt_pkg::*;

    prod_t           p_reg   [6];
    comp_t           c_reg   [3];
    mag_t            m_reg   [3];
    logic [HHW-1:0]  hh_reg  [3];
    logic [HLW-1:0]  hl_reg  [3];
    logic [LLW-1:0]  ll_reg  [3];
    logic [SQW-1:0]  sqc_reg [3];
    rad_t            sq_reg;

    assign sq = sq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= PW'(u.y) * PW'(v.z);
            p_reg[1] <= PW'(u.z) * PW'(v.y);
            p_reg[2] <= PW'(u.z) * PW'(v.x);
            p_reg[3] <= PW'(u.x) * PW'(v.z);
            p_reg[4] <= PW'(u.x) * PW'(v.y);
            p_reg[5] <= PW'(u.y) * PW'(v.x);
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i]  <= CW'(p_reg[2*i]) - CW'(p_reg[2*i+1]);
                m_reg[i]  <= c_reg[i][CW-1] ? MW'(-c_reg[i]) : MW'(c_reg[i]);
                // split the square into half-width products
                hh_reg[i] <= HHW'(m_reg[i][MW-1:LO]) * HHW'(m_reg[i][MW-1:LO]);
                hl_reg[i] <= HLW'(m_reg[i][MW-1:LO]) * HLW'(m_reg[i][LO-1:0]);
                ll_reg[i] <= LLW'(m_reg[i][LO-1:0]) * LLW'(m_reg[i][LO-1:0]);
                sqc_reg[i] <= (SQW'(hh_reg[i]) << (2 * LO)) + (SQW'(hl_reg[i]) << (LO + 1))
                            + SQW'(ll_reg[i]);
            end
            sq_reg <= RADW'(sqc_reg[0]) + RADW'(sqc_reg[1]) + RADW'(sqc_reg[2]);
        end
    end

endmodule

// ===== src/pitt_front.sv =====
module pitt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pitt_pkg::tri_word_t in_word,
    input  pitt_pkg::q_stat_t   q_stat,
    output logic                push,
    output pitt_pkg::sq_set_t   push_data
);
    import pitt_pkg::*;
    `include "assert_macros.svh"

    logic [F_LAST:0] vf_reg;
    logic            en;
    crd_t            a_reg [3];
    crd_t            b_reg [3];
    crd_t            c_reg [3];
    crd_t            q_reg [3];
    vec_t            e1_reg, e2_reg, qa_reg, qb_reg, qc_reg;

    function automatic vec_t vdiff(crd_t px, crd_t py, crd_t pz,
                                   crd_t rx, crd_t ry, crd_t rz);
        vec_t d;
        d.x = dif_t'(px) - dif_t'(rx);
        d.y = dif_t'(py) - dif_t'(ry);
        d.z = dif_t'(pz) - dif_t'(rz);
        return d;
    endfunction

    // hold the whole front while the finished word cannot enter the queue
    assign en       = !(vf_reg[F_LAST] && q_stat.full);
    assign in_stall = !en;
    assign push     = vf_reg[F_LAST] && !q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= '0;
        else if (en)
            vf_reg <= {vf_reg[F_LAST-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= in_word.a_x[COORD_BITS-1:0];
            a_reg[1] <= in_word.a_y[COORD_BITS-1:0];
            a_reg[2] <= in_word.a_z[COORD_BITS-1:0];
            b_reg[0] <= in_word.b_x[COORD_BITS-1:0];
            b_reg[1] <= in_word.b_y[COORD_BITS-1:0];
            b_reg[2] <= in_word.b_z[COORD_BITS-1:0];
            c_reg[0] <= in_word.c_x[COORD_BITS-1:0];
            c_reg[1] <= in_word.c_y[COORD_BITS-1:0];
            c_reg[2] <= in_word.c_z[COORD_BITS-1:0];
            q_reg[0] <= in_word.q_x[COORD_BITS-1:0];
            q_reg[1] <= in_word.q_y[COORD_BITS-1:0];
            q_reg[2] <= in_word.q_z[COORD_BITS-1:0];
            e1_reg <= vdiff(b_reg[0], b_reg[1], b_reg[2], a_reg[0], a_reg[1], a_reg[2]);
            e2_reg <= vdiff(c_reg[0], c_reg[1], c_reg[2], a_reg[0], a_reg[1], a_reg[2]);
            qa_reg <= vdiff(a_reg[0], a_reg[1], a_reg[2], q_reg[0], q_reg[1], q_reg[2]);
            qb_reg <= vdiff(b_reg[0], b_reg[1], b_reg[2], q_reg[0], q_reg[1], q_reg[2]);
            qc_reg <= vdiff(c_reg[0], c_reg[1], c_reg[2], q_reg[0], q_reg[1], q_reg[2]);
        end
    end

    pitt_cross u_whole (.clk(clk), .en(en), .u(e1_reg), .v(e2_reg), .sq(push_data.whole));
    pitt_cross u_sub0  (.clk(clk), .en(en), .u(qb_reg), .v(qc_reg), .sq(push_data.s0));
    pitt_cross u_sub1  (.clk(clk), .en(en), .u(qc_reg), .v(qa_reg), .sq(push_data.s1));
    pitt_cross u_sub2  (.clk(clk), .en(en), .u(qa_reg), .v(qb_reg), .sq(push_data.s2));

    `PITT_ASSERT(a_front_hold, vf_reg[F_LAST] && q_stat.full |=> vf_reg[F_LAST], "front dropped a word")

endmodule

// ===== src/pitt_fifo.sv =====
module pitt_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pitt_pkg::sq_set_t wdata,
    input  logic              pop,
    output pitt_pkg::sq_set_t rdata,
    output pitt_pkg::q_stat_t stat
);
    import pitt_pkg::*;
    `include "assert_macros.svh"

    sq_set_t           mem [Q_DEPTH];
    logic [Q_PTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNTW-1:0] cnt_reg;

    assign rdata      = mem[rd_ptr_reg];
    assign stat.full  = (cnt_reg == Q_CNTW'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    `PITT_NEVER(a_q_overflow, push && stat.full, "push into full queue")
    `PITT_NEVER(a_q_underflow, pop && stat.empty, "pop from empty queue")

endmodule

// ===== src/pitt_isqrt.sv =====
module pitt_isqrt (
    input  logic           clk,
    input  logic           en,
    input  pitt_pkg::rad_t sq,
    output pitt_pkg::root_t root
);
    import pitt_pkg::*;

    sqrt_st_t st_reg [RW+1];

    assign root = st_reg[RW].root;

    // one root bit per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].rad  <= sq;
            st_reg[0].rem  <= '0;
            st_reg[0].root <= '0;
            for (int k = 0; k < RW; k++)
                st_reg[k+1] <= sqrt_step(st_reg[k]);
        end
    end

endmodule

// ===== src/pitt_back.sv =====
module pitt_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pitt_pkg::q_stat_t          q_stat,
    input  pitt_pkg::sq_set_t          qdata,
    output logic                       pop,
    input  logic [pitt_pkg::TOL_W-1:0] tol,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       inside_res,
    output logic                       degenerate
);
    import pitt_pkg::*;
    `include "assert_macros.svh"

    localparam int VB = RW + 3;

    logic [VB-1:0]   vb_reg;
    logic            en;
    root_t           r_whole, r0, r1, r2;
    logic [SW-1:0]   s_reg;
    root_t           whole_reg;
    logic [SW:0]     dd;
    logic [SW-1:0]   diff_reg;
    logic [RHSW-1:0] rhs_reg;
    logic            zero_reg;
    logic            out_vld_reg, inside_reg, deg_reg;
    logic [CMPW-1:0] lhs_c, rhs_c;

    assign en  = !out_vld_reg || !out_stall;
    assign pop = en && !q_stat.empty;

    assign out_valid  = out_vld_reg;
    assign inside_res = inside_reg;
    assign degenerate = deg_reg;

    pitt_isqrt u_rw (.clk(clk), .en(en), .sq(qdata.whole), .root(r_whole));
    pitt_isqrt u_r0 (.clk(clk), .en(en), .sq(qdata.s0),    .root(r0));
    pitt_isqrt u_r1 (.clk(clk), .en(en), .sq(qdata.s1),    .root(r1));
    pitt_isqrt u_r2 (.clk(clk), .en(en), .sq(qdata.s2),    .root(r2));

    assign dd    = {1'b0, s_reg} - (SW+1)'(whole_reg);
    assign lhs_c = CMPW'({diff_reg, {TOL_SHIFT{1'b0}}});
    assign rhs_c = CMPW'(rhs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg      <= {vb_reg[VB-2:0], pop};
            out_vld_reg <= vb_reg[VB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg      <= SW'(r0) + SW'(r1) + SW'(r2);
            whole_reg  <= r_whole;
            diff_reg   <= dd[SW] ? SW'(-dd) : SW'(dd);
            rhs_reg    <= RHSW'(tol) * RHSW'(whole_reg);
            zero_reg   <= (whole_reg == '0);
            inside_reg <= !zero_reg && (lhs_c <= rhs_c);
            deg_reg    <= zero_reg;
        end
    end

    `PITT_ASSERT(a_deg_outside, out_vld_reg && deg_reg |-> !inside_reg, "degenerate reported inside")

endmodule

// ===== src/point_in_triangle_test.sv =====
// Channel   Direction  Handshake            Word
// in        input      in_valid / in_stall   a_x..q_z, 12 x 32-bit signed Q16.16
// out       output     out_valid / out_stall inside_res, degenerate
// cfg       input      cfg_wr_en             cfg_wr_data -> tolerance (16 bit)
//
// One word per cycle in and out while neither in_stall nor out_stall holds the flow.
// The square-root pipeline has 68 stages, one root bit per stage.
// Reset (rst_n low, asynchronous) empties all stages and sets tolerance to 105.
// A stalled output holds the back end; the 4-entry queue then fills and the front
// end raises in_stall once its last stage cannot be written into the queue.
module point_in_triangle_test (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] a_x,
    input  logic [31:0] a_y,
    input  logic [31:0] a_z,
    input  logic [31:0] b_x,
    input  logic [31:0] b_y,
    input  logic [31:0] b_z,
    input  logic [31:0] c_x,
    input  logic [31:0] c_y,
    input  logic [31:0] c_z,
    input  logic [31:0] q_x,
    input  logic [31:0] q_y,
    input  logic [31:0] q_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        inside_res,
    output logic        degenerate
);
    import pitt_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    tri_word_t        in_word;
    q_stat_t          q_stat;
    sq_set_t          push_data, q_data;
    logic             push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_wr_en)
            tol_reg <= cfg_wr_data;
    end

    assign in_word.a_x = a_x;
    assign in_word.a_y = a_y;
    assign in_word.a_z = a_z;
    assign in_word.b_x = b_x;
    assign in_word.b_y = b_y;
    assign in_word.b_z = b_z;
    assign in_word.c_x = c_x;
    assign in_word.c_y = c_y;
    assign in_word.c_z = c_z;
    assign in_word.q_x = q_x;
    assign in_word.q_y = q_y;
    assign in_word.q_z = q_z;

    pitt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    pitt_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_data),
        .pop   (pop),
        .rdata (q_data),
        .stat  (q_stat)
    );

    pitt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .qdata      (q_data),
        .pop        (pop),
        .tol        (tol_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res),
        .degenerate (degenerate)
    );

endmodule

// ===== tb/sv/pitt_checker.sv =====
`timescale 1ns / 1ps

module pitt_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  pitt_pkg::tri_word_t word,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                inside_res,
    input  logic                degenerate,
    output int                  fail_count,
    output int                  pending
);
    import pitt_pkg::*;

    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        logic in_tri;
        logic degen;
    } verdict_t;

    verdict_t    verdicts[$];
    logic [15:0] tol;
    int          reported;

    // floor of the length of u x v
    function automatic logic [191:0] cross_len(wide_t ux, wide_t uy, wide_t uz,
                                               wide_t vx, wide_t vy, wide_t vz);
        wide_t        cx;
        wide_t        cy;
        wide_t        cz;
        logic [191:0] sq;
        logic [191:0] root;
        logic [191:0] cand;
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        sq = cx * cx + cy * cy + cz * cz;
        root = '0;
        for (int b = 69; b >= 0; b--)
        begin
            cand = root | (192'd1 << b);
            if (cand * cand <= sq)
                root = cand;
        end
        return root;
    endfunction

    function automatic verdict_t area_check(tri_word_t w, logic [15:0] t);
        wide_t        ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy, qz;
        logic [191:0] whole;
        logic [191:0] sum;
        logic [191:0] diff;
        verdict_t     v;
        ax = $signed(w.a_x); ay = $signed(w.a_y); az = $signed(w.a_z);
        bx = $signed(w.b_x); by = $signed(w.b_y); bz = $signed(w.b_z);
        cx = $signed(w.c_x); cy = $signed(w.c_y); cz = $signed(w.c_z);
        qx = $signed(w.q_x); qy = $signed(w.q_y); qz = $signed(w.q_z);
        whole = cross_len(bx - ax, by - ay, bz - az, cx - ax, cy - ay, cz - az);
        v = '0;
        if (whole == 0)
        begin
            v.degen = 1'b1;
            return v;
        end
        sum = cross_len(bx - qx, by - qy, bz - qz, cx - qx, cy - qy, cz - qz)
            + cross_len(cx - qx, cy - qy, cz - qz, ax - qx, ay - qy, az - qz)
            + cross_len(ax - qx, ay - qy, az - qz, bx - qx, by - qy, bz - qz);
        diff = (sum >= whole) ? sum - whole : whole - sum;
        v.in_tri = ((diff << 20) <= ({176'd0, t} * whole));
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t e;
        if (!rst_n)
        begin
            tol = TOL_RESET;
            verdicts.delete();
            fail_count = 0;
            reported = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts.size() == 0)
                begin
                    fail_count++;
                    if (reported < 10)
                        $display("unexpected result word inside=%0b degenerate=%0b",
                                 inside_res, degenerate);
                    reported++;
                end
                else
                begin
                    e = verdicts.pop_front();
                    if (e.in_tri !== inside_res || e.degen !== degenerate)
                    begin
                        fail_count++;
                        if (reported < 10)
                            $display("mismatch: inside exp %0b got %0b, %s %0b got %0b",
                                     e.in_tri, inside_res, "degenerate exp",
                                     e.degen, degenerate);
                        reported++;
                    end
                end
            end
            if (in_valid && !in_stall)
                verdicts.push_back(area_check(word, tol));
            if (cfg_wr_en)
                tol = cfg_wr_data;
            pending = verdicts.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pitt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    tri_word_t   word;
    logic        out_valid;
    logic        out_stall;
    logic        inside_res;
    logic        degenerate;
    int          fail_count;
    int          pending;

    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;

    point_in_triangle_test u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .a_x         (word.a_x),
        .a_y         (word.a_y),
        .a_z         (word.a_z),
        .b_x         (word.b_x),
        .b_y         (word.b_y),
        .b_z         (word.b_z),
        .c_x         (word.c_x),
        .c_y         (word.c_y),
        .c_z         (word.c_z),
        .q_x         (word.q_x),
        .q_y         (word.q_y),
        .q_z         (word.q_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .inside_res  (inside_res),
        .degenerate  (degenerate)
    );

    pitt_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .word        (word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .inside_res  (inside_res),
        .degenerate  (degenerate),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stall, or one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // keep valid high straight into the next word; drop it only while idle
    task automatic send_word(input tri_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        word     <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_tol(input logic [15:0] t);
        idle_input();
        wait (pending == 0);
        repeat (100) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= t;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic tri_word_t noise_word();
        tri_word_t w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return w;
    endfunction

    // triangle with query point built from weights u/256, v/256, optionally pushed off
    function automatic tri_word_t planar_word(int span);
        tri_word_t   w;
        longint      a[3], b[3], c[3], q[3];
        longint      u, v;
        longint      off;
        u = $urandom_range(300);
        v = $urandom_range(300 - u);
        off = ($urandom_range(3) == 0) ? $urandom_range(2000) : 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'($urandom_range(2 * span)) - span;
            b[i] = longint'($urandom_range(2 * span)) - span;
            c[i] = longint'($urandom_range(2 * span)) - span;
            q[i] = a[i] + ((u * (b[i] - a[i]) + v * (c[i] - a[i])) >>> 8) + off;
        end
        if ($urandom_range(15) == 0)
            c = b;
        w = {a[0][31:0], a[1][31:0], a[2][31:0], b[0][31:0], b[1][31:0], b[2][31:0],
             c[0][31:0], c[1][31:0], c[2][31:0], q[0][31:0], q[1][31:0], q[2][31:0]};
        return w;
    endfunction

    initial
    begin
        tri_word_t w;
        logic [31:0] mx;
        logic [31:0] mn;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_valid       = 1'b0;
        word           = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at reset tolerance
        send_word('0);
        send_word({12{mx}});
        send_word({12{mn}});
        send_word({mn, mn, mn, mx, mn, mn, mn, mx, mn, mn, mn, mn});
        send_word({mn, mn, mn, mx, mx, mx, mn, mx, mx, mx, mn, mx});
        send_word({mx, mx, mx, mn, mx, mn, mx, mn, mn, 32'd0, 32'd0, 32'd0});
        // right triangle with legs of 0x30000 in xy, points inside, on vertex, on edge, outside, off plane
        w = {32'd0, 32'd0, 32'd0, 32'h30000, 32'd0, 32'd0, 32'd0, 32'h30000, 32'd0,
             32'h10000, 32'h10000, 32'd0};
        send_word(w);
        w.q_x = 32'd0; w.q_y = 32'd0; send_word(w);
        w.q_x = 32'h18000; w.q_y = 32'h18000; send_word(w);
        w.q_x = 32'h40000; send_word(w);
        w.q_x = 32'h10000; w.q_y = 32'h10000; w.q_z = 32'h1; send_word(w);
        w.q_z = 32'hffff0000; send_word(w);
        // collinear vertices
        w = {32'd0, 32'd0, 32'd0, 32'h10000, 32'h10000, 32'h10000,
             32'h20000, 32'h20000, 32'h20000, 32'h10000, 32'h10000, 32'h10000};
        send_word(w);
        for (int i = 0; i < 6; i++)
            send_word(planar_word(1 << 28));

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                1: write_tol(16'd0);
                2: write_tol(16'd65535);
                3: write_tol(16'd105);
                4: write_tol(16'd1);
                default: if (p > 0) write_tol(16'($urandom_range(65535)));
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 69;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 69;
                end
                default:
                begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            if (p == 0 || p == 5)
                hold_req = 1'b1;
            for (int i = 0; i < 85; i++)
            begin
                if (i == 40)
                begin
                    idle_input();
                    wait (pending == 0);
                end
                if ($urandom_range(4) == 0)
                    send_word(noise_word());
                else
                    send_word(planar_word(($urandom_range(3) == 0) ? (1 << 30)
                                          : (1 << $urandom_range(28, 4))));
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        idle_input();
        wait (pending == 0);
        repeat (120) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
